@@ rtl/sfbs_pkg.sv @@
// shared types and constants of the split-frame balance steering block
package sfbs_pkg;

  // field widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned AVG_W   = 8;
  localparam int unsigned CMD_W   = 11;
  localparam int unsigned ROW_W   = 14;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned VEL_W   = 10;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned IDX_W   = 3;

  // frame bookkeeping widths
  localparam int unsigned COL_W   = 13;
  localparam int unsigned TOT_W   = 22;
  localparam int unsigned SUM_W   = 30;
  localparam int unsigned HALF_W  = TOT_W - 1;
  localparam int unsigned DVS_W   = HALF_W + AVG_W - 1;

  // working width of the velocity arithmetic
  localparam int unsigned WRK_W   = 13;

  // limits
  localparam logic [TOT_W-1:0] MAX_FRAME_BYTES = TOT_W'(2097152);
  localparam logic [ROW_W-1:0] MAX_ROW_BYTES   = ROW_W'(8192);

  // divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = AVG_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ROW_BYTES         = 3'd0,
    REG_BALANCE_THRESHOLD = 3'd1,
    REG_ANGULAR_STEP      = 3'd2,
    REG_ANGULAR_LIMIT     = 3'd3,
    REG_LINEAR_STEP       = 3'd4,
    REG_LINEAR_LIMIT      = 3'd5,
    REG_LINEAR_BASE       = 3'd6
  } cfg_reg_e;

  // controller to datapath
  typedef struct packed {
    logic accept;     // an input item is taken this cycle
    logic div_start;  // load the dividers from the frame sums
    logic div_step;   // one quotient bit
    logic vel_load;   // update velocities, fill output, clear frame
  } sfbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a new item
  } sfbs_status_t;

endpackage

@@ rtl/sfbs_div.sv @@
// restoring divider for one half average, saturated at 255
module sfbs_div import sfbs_pkg::*; (
  input  logic              clk_i,
  input  logic              start_i,
  input  logic              step_i,
  input  logic [SUM_W-1:0]  sum_i,
  input  logic [HALF_W-1:0] half_i,
  output logic [AVG_W-1:0]  avg_o
);

  logic [SUM_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [AVG_W-1:0] quo_q, quo_d;
  logic             zero_q, zero_d;
  logic             sat_q, sat_d;
  logic [SUM_W-1:0] dvs_ext;

  assign dvs_ext = SUM_W'(dvs_q);

  // load on start, then one compare and subtract per step
  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    zero_d = zero_q;
    sat_d  = sat_q;
    if (start_i) begin
      rem_d  = sum_i;
      dvs_d  = {half_i, {(AVG_W-1){1'b0}}};
      quo_d  = '0;
      zero_d = (half_i == '0);
      sat_d  = (sum_i >= SUM_W'({half_i, {AVG_W{1'b0}}}));
    end else if (step_i) begin
      if (rem_q >= dvs_ext) begin
        rem_d = rem_q - dvs_ext;
        quo_d = {quo_q[AVG_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[AVG_W-2:0], 1'b0};
      end
      dvs_d = dvs_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
    sat_q  <= sat_d;
  end

  // empty frame half gives zero, an oversized quotient saturates
  assign avg_o = zero_q ? '0 : (sat_q ? '1 : quo_q);

endmodule

@@ rtl/sfbs_datapath.sv @@
// frame accumulators, config registers, dividers and velocity update
module sfbs_datapath import sfbs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic [PIX_W-1:0]        pixel_byte_i,
  input  logic                    out_stall_i,
  input  sfbs_cmd_t               cmd_i,
  output sfbs_status_t            status_o,
  output logic                    out_valid_o,
  output logic signed [CMD_W-1:0] angular_cmd_o,
  output logic signed [CMD_W-1:0] linear_cmd_o,
  output logic [AVG_W-1:0]        left_average_o,
  output logic [AVG_W-1:0]        right_average_o
);

  // configuration registers
  logic [ROW_W-1:0] row_bytes_q;
  logic [THR_W-1:0] thr_q;
  logic [VEL_W-1:0] ang_step_q, ang_limit_q, lin_step_q, lin_limit_q, lin_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= ROW_W'(5760);
      thr_q       <= THR_W'(9);
      ang_step_q  <= VEL_W'(50);
      ang_limit_q <= VEL_W'(500);
      lin_step_q  <= VEL_W'(50);
      lin_limit_q <= VEL_W'(300);
      lin_base_q  <= VEL_W'(70);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROW_BYTES:         row_bytes_q <= cfg_data_i[ROW_W-1:0];
        REG_BALANCE_THRESHOLD: thr_q       <= cfg_data_i[THR_W-1:0];
        REG_ANGULAR_STEP:      ang_step_q  <= cfg_data_i[VEL_W-1:0];
        REG_ANGULAR_LIMIT:     ang_limit_q <= cfg_data_i[VEL_W-1:0];
        REG_LINEAR_STEP:       lin_step_q  <= cfg_data_i[VEL_W-1:0];
        REG_LINEAR_LIMIT:      lin_limit_q <= cfg_data_i[VEL_W-1:0];
        REG_LINEAR_BASE:       lin_base_q  <= cfg_data_i[VEL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective row width, clamped to 1..MAX_ROW_BYTES
  logic [ROW_W-1:0] row_eff;
  logic [COL_W-1:0] row_half;
  always_comb begin
    if (row_bytes_q == '0) begin
      row_eff = ROW_W'(1);
    end else if (row_bytes_q > MAX_ROW_BYTES) begin
      row_eff = MAX_ROW_BYTES;
    end else begin
      row_eff = row_bytes_q;
    end
    row_half = COL_W'(row_eff >> 1);
  end

  // frame accumulation
  logic [COL_W-1:0] col_q, col_d;
  logic [TOT_W-1:0] tot_q, tot_d;
  logic [SUM_W-1:0] lsum_q, lsum_d, rsum_q, rsum_d;
  logic [ROW_W-1:0] col_inc;

  assign col_inc = ROW_W'(col_q) + ROW_W'(1);

  always_comb begin
    col_d  = col_q;
    tot_d  = tot_q;
    lsum_d = lsum_q;
    rsum_d = rsum_q;
    if (cmd_i.vel_load) begin
      col_d  = '0;
      tot_d  = '0;
      lsum_d = '0;
      rsum_d = '0;
    end else if (cmd_i.accept) begin
      if (tot_q < MAX_FRAME_BYTES) begin
        if (col_q < row_half) begin
          lsum_d = lsum_q + SUM_W'(pixel_byte_i);
        end else begin
          rsum_d = rsum_q + SUM_W'(pixel_byte_i);
        end
        tot_d = tot_q + TOT_W'(1);
      end
      col_d = (col_inc >= row_eff) ? '0 : col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      tot_q  <= '0;
      lsum_q <= '0;
      rsum_q <= '0;
    end else begin
      col_q  <= col_d;
      tot_q  <= tot_d;
      lsum_q <= lsum_d;
      rsum_q <= rsum_d;
    end
  end

  // averages over half the frame byte count
  logic [AVG_W-1:0] la, ra;

  sfbs_div u_div_left (
    .clk_i   (clk_i),
    .start_i (cmd_i.div_start),
    .step_i  (cmd_i.div_step),
    .sum_i   (lsum_q),
    .half_i  (tot_q[TOT_W-1:1]),
    .avg_o   (la)
  );

  sfbs_div u_div_right (
    .clk_i   (clk_i),
    .start_i (cmd_i.div_start),
    .step_i  (cmd_i.div_step),
    .sum_i   (rsum_q),
    .half_i  (tot_q[TOT_W-1:1]),
    .avg_o   (ra)
  );

  // velocity update
  logic signed [CMD_W-1:0] ang_q;
  logic signed [WRK_W-1:0] a_step, a_lim, l_step, l_lim, l_base;
  logic signed [WRK_W-1:0] ang0, ang1, lin0, lin1, lin_up;
  logic [AVG_W-1:0]        diff;
  logic                    balanced, left_brighter;

  always_comb begin
    a_step        = WRK_W'(ang_step_q);
    a_lim         = WRK_W'(ang_limit_q);
    l_step        = WRK_W'(lin_step_q);
    l_lim         = WRK_W'(lin_limit_q);
    l_base        = WRK_W'(lin_base_q);
    left_brighter = (la > ra);
    diff          = left_brighter ? (la - ra) : (ra - la);
    balanced      = (diff < thr_q);

    // balanced halves: stop turning, speed up
    lin_up = l_base + l_step;
    if (balanced) begin
      ang0 = '0;
      lin0 = (lin_up > l_lim) ? l_lim : lin_up;
    end else begin
      ang0 = WRK_W'(ang_q);
      lin0 = l_base;
    end

    // turn away from the brighter half (right on a tie), then step the linear velocity down
    if (left_brighter) begin
      ang1 = ang0 - a_step;
      if (ang1 < -a_lim) begin
        ang1 = -a_lim;
      end
    end else begin
      ang1 = ang0 + a_step;
      if (ang1 > a_lim) begin
        ang1 = a_lim;
      end
    end

    lin1 = lin0 - l_step;
    if (lin1 < -l_lim) begin
      lin1 = -l_lim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q <= '0;
    end else if (cmd_i.vel_load) begin
      ang_q <= CMD_W'(ang1);
    end
  end

  // output register
  logic                    out_valid_q;
  logic signed [CMD_W-1:0] ang_out_q, lin_out_q;
  logic [AVG_W-1:0]        la_out_q, ra_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.vel_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vel_load) begin
      ang_out_q <= CMD_W'(ang1);
      lin_out_q <= CMD_W'(lin1);
      la_out_q  <= la;
      ra_out_q  <= ra;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign angular_cmd_o     = ang_out_q;
  assign linear_cmd_o      = lin_out_q;
  assign left_average_o    = la_out_q;
  assign right_average_o   = ra_out_q;

endmodule

@@ rtl/sfbs_ctrl.sv @@
// controller: byte intake, end-of-frame division and update sequence
module sfbs_ctrl import sfbs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         frame_last_i,
  input  sfbs_status_t status_i,
  output logic         in_stall_o,
  output sfbs_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_UPDATE
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             accept;

  assign in_stall_o = (state_q != ST_ACCUM);
  assign accept     = in_valid_i && !in_stall_o;

  // command decode
  always_comb begin
    cmd_o.accept    = accept;
    cmd_o.div_start = (state_q == ST_DIV_INIT);
    cmd_o.div_step  = (state_q == ST_DIV_RUN);
    cmd_o.vel_load  = (state_q == ST_UPDATE) && status_i.out_free;
  end

  // sequence state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_ACCUM: begin
          if (accept && frame_last_i) begin
            state_q <= ST_DIV_INIT;
          end
        end
        ST_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (status_i.out_free) begin
            state_q <= ST_ACCUM;
          end
        end
        default: state_q <= ST_ACCUM;
      endcase
    end
  end

endmodule

@@ rtl/split_frame_balance_steering_top.sv @@
// Split-frame balance steering: one byte item per cycle inside a frame.
// The last byte starts a stalled sequence: divider load, 8 quotient steps in
// one restoring divider per half, velocity update; the result is loaded into
// the output register in the update state, which holds while an earlier
// result still waits there. Reset is asynchronous, active low: config returns
// to defaults, sums, counters and angular velocity clear.
module split_frame_balance_steering_top import sfbs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [PIX_W-1:0]        pixel_byte_i,
  input  logic                    frame_last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [CMD_W-1:0] angular_cmd_o,
  output logic signed [CMD_W-1:0] linear_cmd_o,
  output logic [AVG_W-1:0]        left_average_o,
  output logic [AVG_W-1:0]        right_average_o
);

  sfbs_cmd_t    cmd;
  sfbs_status_t status;

  sfbs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .frame_last_i (frame_last_i),
    .status_i     (status),
    .in_stall_o   (in_stall_o),
    .cmd_o        (cmd)
  );

  sfbs_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pixel_byte_i    (pixel_byte_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .angular_cmd_o   (angular_cmd_o),
    .linear_cmd_o    (linear_cmd_o),
    .left_average_o  (left_average_o),
    .right_average_o (right_average_o)
  );

endmodule
